// ----- design/graph_bfs_distance_assert.svh -----
// assertion macros for the graph bfs distance block
// included by the top level, no other dependencies
`ifndef GRAPH_BFS_DISTANCE_ASSERT_SVH
`define GRAPH_BFS_DISTANCE_ASSERT_SVH
`ifndef SYNTHESIS
`define GBFS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbfs check failed");
`define GBFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbfs check failed");
`else
`define GBFS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define GBFS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/gbfs_pkg.sv -----
// shared types and constants for the graph bfs distance block
// no dependencies
`default_nettype none
package gbfs_pkg;

    localparam int MAX_NODES_DEF  = 64;
    localparam int MAX_DEGREE_DEF = 16;
    localparam int NODE_W = 6;
    localparam int LVL_W  = 6;
    localparam int DIST_W = 7;
    localparam int SUM_W  = 18;
    localparam int NC_W   = 7;
    localparam int REQ_W  = 3;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;
    localparam logic [NC_W-1:0] NC_RESET = 7'd64;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR = 3'd0,
        REQ_ADD   = 3'd1,
        REQ_QUERY = 3'd2,
        REQ_READ  = 3'd3,
        REQ_SUM   = 3'd4
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ADD_WR,
        ST_RD_OUT,
        ST_SUM_NEXT,
        ST_POP,
        ST_LOADU,
        ST_DEGQ,
        ST_SCAN,
        ST_Q_OUT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic accept;
        logic clear_graph;
        logic add_wr;
        logic seed;
        logic sum_init;
        logic sum_fin;
        logic pop;
        logic loadu;
        logic degq;
        logic scan;
        logic q_out;
        logic rd_out;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        req_t req;
        logic q_empty;
        logic scan_done;
        logic sum_done;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// ----- design/graph_bfs_distance.sv -----
// Directed graph with breadth-first hop distances. One request in, one result
// out. A query runs a breadth-first search that takes each reached node from
// the queue in turn and scans its out edges; the edge scan reads one adjacency
// entry per cycle from the single adjacency memory port. Sum repeats that
// search once for every node in use. Requests are taken one at a time; the
// result register lets the next request enter while a result still waits.
// top level, depends on gbfs_pkg, gbfs_ctrl, gbfs_dpath and the assertion header
`default_nettype none
`include "graph_bfs_distance_assert.svh"
module graph_bfs_distance import gbfs_pkg::*; #(
    parameter int MAX_NODES  = MAX_NODES_DEF,
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_tvalid,
    output logic                    s_tready,
    // req_type[2:0], src_node[8:3], dst_node[14:9], zero fill
    input  wire  [IN_TDATA_W-1:0]   s_tdata,
    output logic                    m_tvalid,
    input  wire                     m_tready,
    // distance[6:0], total_sum[24:7], rejected[25], zero fill
    output logic [OUT_TDATA_W-1:0]  m_tdata,
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    // node_count
    input  wire  [NC_W-1:0]         cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    gbfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gbfs_dpath #(
        .MAX_NODES  (MAX_NODES),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // one request at a time
    `GBFS_ASSERT_NEXT(a_one_req, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // a result is never loaded over one still waiting
    `GBFS_ASSERT_SAME(a_no_overwrite, aclk, aresetn, cmd.out_load, !m_tvalid || m_tready)
    // a rejected add carries no distance and no sum
    `GBFS_ASSERT_SAME(a_rej_fields, aclk, aresetn, m_tvalid && m_tdata[25], m_tdata[24:0] == 25'h7f)

endmodule
`default_nettype wire

// ----- design/gbfs_ctrl.sv -----
// request sequencer for the graph bfs distance block
// depends on gbfs_pkg
`default_nettype none
module gbfs_ctrl import gbfs_pkg::*; (
    input  wire  aclk,
    input  wire  aresetn,
    input  wire  s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                unique case (sts.req)
                    REQ_ADD:   state_next = ST_ADD_WR;
                    REQ_QUERY: state_next = ST_POP;
                    REQ_READ:  state_next = ST_RD_OUT;
                    REQ_SUM:   state_next = ST_SUM_NEXT;
                    default:   state_next = ST_RESULT;
                endcase
            end
            ST_ADD_WR:   state_next = ST_RESULT;
            ST_RD_OUT:   state_next = ST_RESULT;
            ST_SUM_NEXT: state_next = sts.sum_done ? ST_RESULT : ST_POP;
            ST_POP: begin
                if (!sts.q_empty) begin
                    state_next = ST_LOADU;
                end else if (sts.req == REQ_QUERY) begin
                    state_next = ST_Q_OUT;
                end else begin
                    state_next = ST_SUM_NEXT;
                end
            end
            ST_LOADU: state_next = ST_DEGQ;
            ST_DEGQ:  state_next = ST_SCAN;
            ST_SCAN: begin
                if (sts.scan_done) state_next = ST_POP;
            end
            ST_Q_OUT: state_next = ST_RESULT;
            ST_RESULT: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_DECODE: begin
                cmd.clear_graph = (sts.req == REQ_CLEAR);
                cmd.seed        = (sts.req == REQ_QUERY);
                cmd.sum_init    = (sts.req == REQ_SUM);
            end
            ST_ADD_WR: cmd.add_wr = 1'b1;
            ST_RD_OUT: cmd.rd_out = 1'b1;
            ST_SUM_NEXT: begin
                cmd.sum_fin = sts.sum_done;
                cmd.seed    = !sts.sum_done;
            end
            ST_POP:   cmd.pop   = !sts.q_empty;
            ST_LOADU: cmd.loadu = 1'b1;
            ST_DEGQ:  cmd.degq  = 1'b1;
            ST_SCAN:  cmd.scan  = 1'b1;
            ST_Q_OUT: cmd.q_out = 1'b1;
            ST_RESULT: cmd.out_load = sts.out_free;
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- design/gbfs_dpath.sv -----
// graph storage, bfs queue, distance table and result registers
// depends on gbfs_pkg, driven by gbfs_ctrl commands
`default_nettype none
module gbfs_dpath import gbfs_pkg::*; #(
    parameter int MAX_NODES  = MAX_NODES_DEF,
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire  [IN_TDATA_W-1:0]   s_tdata,
    input  wire                     cfg_valid,
    input  wire  [NC_W-1:0]         cfg_data,
    input  cmd_t                    cmd,
    output sts_t                    sts,
    output logic                    m_tvalid,
    input  wire                     m_tready,
    output logic [OUT_TDATA_W-1:0]  m_tdata
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int DGW = $clog2(MAX_DEGREE + 1);
    localparam int AW  = $clog2(MAX_NODES * MAX_DEGREE);
    localparam int QW  = NODE_W + LVL_W;

    // request and configuration
    req_t              req_reg;
    logic [NODE_W-1:0] s_reg, t_reg;
    logic [NC_W-1:0]   nc_reg;

    // per node flags: has out edges, has in edges, table entry valid, visited
    logic [MAX_NODES-1:0] onz_reg, innz_reg, tvld_reg, vis_reg;

    logic [DGW-1:0]    odeg_mem [MAX_NODES];
    logic [NODE_W-1:0] adj_mem  [MAX_NODES*MAX_DEGREE];
    logic [LVL_W-1:0]  dist_mem [MAX_NODES];
    logic [QW-1:0]     q_mem    [MAX_NODES];

    logic [DGW-1:0]    odeg_q;
    logic [NODE_W-1:0] adj_q;
    logic [LVL_W-1:0]  dist_q;
    logic [QW-1:0]     q_q;

    logic [NW:0]       head_reg, tail_reg;
    logic [NODE_W-1:0] u_reg;
    logic [LVL_W-1:0]  lvl_reg;
    logic [DGW-1:0]    deg_reg, j_reg;
    logic              pend_reg;
    logic [NC_W-1:0]   src_reg;
    logic [SUM_W-1:0]  total_reg;

    logic [DIST_W-1:0] res_dist_reg;
    logic [SUM_W-1:0]  res_sum_reg;
    logic              res_rej_reg;
    logic              m_tvalid_reg;
    logic [DIST_W-1:0] m_dist_reg;
    logic [SUM_W-1:0]  m_sum_reg;
    logic              m_rej_reg;

    function automatic logic node_ok(input logic [NODE_W-1:0] node,
                                     input logic [NC_W-1:0] nc);
        node_ok = ({1'b0, node} < nc) && (32'(node) < MAX_NODES);
    endfunction

    function automatic logic [NW-1:0] idx(input logic [NODE_W-1:0] node);
        idx = NW'(node);
    endfunction

    // add edge
    logic [DGW-1:0] add_deg;
    logic           add_rej;
    assign add_deg = onz_reg[idx(s_reg)] ? odeg_q : '0;
    assign add_rej = !node_ok(s_reg, nc_reg) || !node_ok(t_reg, nc_reg)
                     || (32'(add_deg) >= MAX_DEGREE);

    // seeding a search
    logic                 is_query;
    logic [NODE_W-1:0]    seed_node;
    logic                 seed_ok;
    logic [MAX_NODES-1:0] seed_mask;
    assign is_query  = (req_reg == REQ_QUERY);
    assign seed_node = is_query ? s_reg : src_reg[NODE_W-1:0];
    assign seed_ok   = is_query ? node_ok(s_reg, nc_reg) : 1'b1;
    assign seed_mask = {{(MAX_NODES-1){1'b0}}, 1'b1} << idx(seed_node);

    // edge scan: the neighbor read last cycle is checked now
    logic              visit;
    logic [LVL_W-1:0]  nlvl;
    logic              scan_issue;
    assign nlvl       = lvl_reg + 1'b1;
    assign visit      = cmd.scan && pend_reg && node_ok(adj_q, nc_reg)
                        && !vis_reg[idx(adj_q)];
    assign scan_issue = cmd.scan && (j_reg < deg_reg);

    logic [SUM_W:0] sum_wide;
    assign sum_wide = {1'b0, total_reg} + (SUM_W+1)'(nlvl);

    // memory ports
    logic [NW-1:0] odeg_ra;
    logic [AW-1:0] adj_ra, adj_wa;
    assign odeg_ra = cmd.loadu ? idx(q_q[NODE_W-1:0]) : idx(s_reg);
    assign adj_ra  = AW'(idx(u_reg)) * AW'(MAX_DEGREE) + AW'(j_reg);
    assign adj_wa  = AW'(idx(s_reg)) * AW'(MAX_DEGREE) + AW'(add_deg);

    logic              q_we;
    logic [NW-1:0]     q_wa;
    logic [QW-1:0]     q_wd;
    logic              d_we;
    logic [NW-1:0]     d_wa;
    logic [LVL_W-1:0]  d_wd;
    logic              add_ok;
    assign add_ok = cmd.add_wr && !add_rej;

    always_comb begin
        q_we = 1'b0;
        q_wa = tail_reg[NW-1:0];
        q_wd = {nlvl, adj_q};
        d_we = 1'b0;
        d_wa = idx(adj_q);
        d_wd = nlvl;
        priority if (cmd.seed) begin
            q_we = seed_ok;
            q_wa = '0;
            q_wd = {{LVL_W{1'b0}}, seed_node};
            d_we = seed_ok && is_query;
            d_wa = idx(seed_node);
            d_wd = '0;
        end else if (visit) begin
            q_we = 1'b1;
            d_we = is_query;
        end
    end

    always_ff @(posedge aclk) begin
        if (add_ok) begin
            odeg_mem[idx(s_reg)] <= add_deg + 1'b1;
            adj_mem[adj_wa]      <= t_reg;
        end
        odeg_q <= odeg_mem[odeg_ra];
        adj_q  <= adj_mem[adj_ra];
    end

    always_ff @(posedge aclk) begin
        if (q_we) q_mem[q_wa] <= q_wd;
        q_q <= q_mem[head_reg[NW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (d_we) dist_mem[d_wa] <= d_wd;
        dist_q <= dist_mem[is_query ? idx(t_reg) : idx(s_reg)];
    end

    // request, config, flags, search control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nc_reg   <= NC_RESET;
            onz_reg  <= '0;
            innz_reg <= '0;
            tvld_reg <= '0;
            vis_reg  <= '0;
            pend_reg <= 1'b0;
            req_reg  <= REQ_CLEAR;
        end else begin
            if (cfg_valid) nc_reg <= cfg_data;
            if (cmd.accept) begin
                req_reg <= req_t'(s_tdata[REQ_W-1:0]);
                s_reg   <= s_tdata[REQ_W +: NODE_W];
                t_reg   <= s_tdata[REQ_W+NODE_W +: NODE_W];
            end
            if (cmd.clear_graph) begin
                onz_reg  <= '0;
                innz_reg <= '0;
            end
            if (add_ok) begin
                onz_reg[idx(s_reg)]  <= 1'b1;
                innz_reg[idx(t_reg)] <= 1'b1;
            end
            if (cmd.seed) begin
                head_reg <= '0;
                tail_reg <= seed_ok ? (NW+1)'(1) : '0;
                vis_reg  <= seed_ok ? seed_mask : '0;
                if (is_query) tvld_reg <= seed_ok ? seed_mask : '0;
                if (!is_query) src_reg <= src_reg + 1'b1;
            end
            if (cmd.sum_init) begin
                src_reg   <= '0;
                total_reg <= '0;
            end
            if (cmd.pop) head_reg <= head_reg + 1'b1;
            if (cmd.loadu) begin
                u_reg   <= q_q[NODE_W-1:0];
                lvl_reg <= q_q[QW-1:NODE_W];
            end
            if (cmd.degq) begin
                deg_reg  <= onz_reg[idx(u_reg)] ? odeg_q : '0;
                j_reg    <= '0;
                pend_reg <= 1'b0;
            end
            if (cmd.scan) begin
                pend_reg <= scan_issue;
                if (scan_issue) j_reg <= j_reg + 1'b1;
            end
            if (visit) begin
                vis_reg[idx(adj_q)] <= 1'b1;
                tail_reg <= tail_reg + 1'b1;
                if (is_query) begin
                    tvld_reg[idx(adj_q)] <= 1'b1;
                end else begin
                    total_reg <= sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
                end
            end
        end
    end

    // result assembly
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            res_dist_reg <= '1;
            res_sum_reg  <= '0;
            res_rej_reg  <= 1'b0;
        end
        if (cmd.add_wr) res_rej_reg <= add_rej;
        if (cmd.sum_fin) res_sum_reg <= total_reg;
        if (cmd.rd_out) begin
            res_dist_reg <= (node_ok(s_reg, nc_reg) && tvld_reg[idx(s_reg)])
                            ? {1'b0, dist_q} : '1;
        end
        if (cmd.q_out) begin
            priority if (s_reg == t_reg) begin
                res_dist_reg <= '0;
            end else if (!node_ok(s_reg, nc_reg) || !onz_reg[idx(s_reg)]
                         || !node_ok(t_reg, nc_reg) || !innz_reg[idx(t_reg)]
                         || !tvld_reg[idx(t_reg)]) begin
                res_dist_reg <= '1;
            end else begin
                res_dist_reg <= {1'b0, dist_q};
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_dist_reg <= res_dist_reg;
            m_sum_reg  <= res_sum_reg;
            m_rej_reg  <= res_rej_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-DIST_W-SUM_W-1){1'b0}},
                       m_rej_reg, m_sum_reg, m_dist_reg};

    assign sts.req       = req_reg;
    assign sts.q_empty   = (head_reg == tail_reg);
    assign sts.scan_done = (j_reg >= deg_reg) && !pend_reg;
    assign sts.sum_done  = ({1'b0, src_reg} >= {1'b0, nc_reg})
                           || (32'(src_reg) >= MAX_NODES) || src_reg[NODE_W];
    assign sts.out_free  = !m_tvalid_reg || m_tready;

endmodule
`default_nettype wire
